// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define CMA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cma assertion failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define CMA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cma assertion failed");

`endif

// ===== hdl/cma_pkg.sv =====
`default_nettype none

package cma_pkg;

    localparam int HALF_W     = 5;
    localparam int HALF_LIMIT = 31;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== hdl/cma_ram.sv =====
`default_nettype none

module cma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/cma_div.sv =====
`default_nettype none

module cma_div import cma_pkg::*; #(
    parameter int SUM_W = 22,
    parameter int CNT_W = 6,
    parameter int OUT_W = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [SUM_W-1:0] sum,
    input  wire logic        [CNT_W-1:0] count,
    output div_stat_t                    stat,
    output logic             [OUT_W-1:0] mean
);

    // Rounded quotient (2|sum| + c) / (2c), one restoring step per cycle.
    localparam int NW = SUM_W + 1;
    localparam int DW = CNT_W + 1;
    localparam int RW = CNT_W + 2;
    localparam int IW = $clog2(NW + 1);

    logic [NW-1:0]    num_reg, num_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic             neg_reg, neg_next;
    logic [IW-1:0]    iter_reg, iter_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [OUT_W-1:0] mean_reg, mean_next;

    logic [SUM_W-1:0] mag;
    logic [NW-1:0]    num_init;
    logic [RW-1:0]    rem_sh;
    logic [RW-1:0]    den_ext;
    logic             ge;
    logic [NW-1:0]    quot;

    assign mag      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    assign num_init = {mag, 1'b0} + NW'(count);
    assign rem_sh   = {rem_reg, num_reg[NW-1]};
    assign den_ext  = {1'b0, den_reg};
    assign ge       = rem_sh >= den_ext;
    assign quot     = {num_reg[NW-2:0], ge};

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        mean_next = mean_reg;
        if (start) begin
            num_next  = num_init;
            den_next  = {count, 1'b0};
            rem_next  = '0;
            neg_next  = sum[SUM_W-1];
            iter_next = IW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next  = quot;
            // the partial remainder always stays below the divisor
            rem_next  = ge ? DW'(rem_sh - den_ext) : DW'(rem_sh);
            iter_next = iter_reg - IW'(1);
            if (iter_reg == IW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                mean_next = neg_reg ? (-quot[OUT_W-1:0]) : quot[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        iter_reg <= iter_next;
        mean_reg <= mean_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign mean      = mean_reg;

endmodule

`default_nettype wire

// ===== hdl/centered_moving_average.sv =====
// After the transaction that completes its window, a result is checked (S_CHECK),
// divided (S_DIV) and registered out (S_OUT, held while m_tready is low). Input is taken
// only in S_IDLE. Each result costs one pass through the shared radix-2 divider
// (SAMPLE_WIDTH + log2(depth) + 1 steps) plus, when due, an oldest-sample drop (S_DRD, S_DWT).
// A final sample flushes pending results at the same cost each before the next is taken.
// Reset (aresetn low, synchronous): half_window 0, trace state cleared, no output valid.
`default_nettype none

`include "assert_macros.svh"

module centered_moving_average import cma_pkg::*; #(
    parameter int MAX_HALF_WINDOW = 31,
    parameter int SAMPLE_WIDTH    = 16,
    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wen,
    input  wire logic [HALF_W-1:0]  cfg_wdata,   // half_window
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,     // sample
    input  wire logic               s_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [TDATA_W-1:0] m_tdata,     // mean
    output logic                    m_tlast
);

    localparam int H_LIM = (MAX_HALF_WINDOW < HALF_LIMIT) ? MAX_HALF_WINDOW : HALF_LIMIT;
    localparam int PTR_W = $clog2(2 * H_LIM + 2);
    localparam int DEPTH = 1 << PTR_W;
    localparam int CMP_W = PTR_W + 1;
    localparam int SUM_W = SAMPLE_WIDTH + PTR_W;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] S_CHECK = 3'd1;
    localparam logic [ST_W-1:0] S_DIV   = 3'd2;
    localparam logic [ST_W-1:0] S_OUT   = 3'd3;
    localparam logic [ST_W-1:0] S_DRD   = 3'd4;
    localparam logic [ST_W-1:0] S_DWT   = 3'd5;

    logic [ST_W-1:0]         state_reg, state_next;
    logic [HALF_W-1:0]       half_reg, half_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [PTR_W-1:0]        wptr_reg, wptr_next;
    logic [PTR_W-1:0]        rcv_reg, rcv_next;
    logic [PTR_W-1:0]        cov_reg, cov_next;
    logic [PTR_W-1:0]        pend_reg, pend_next;
    logic                    main_reg, main_next;
    logic                    fin_reg, fin_next;
    logic                    olast_reg, olast_next;
    logic                    drop_reg, drop_next;
    logic                    mvalid_reg, mvalid_next;
    logic [SAMPLE_WIDTH-1:0] mdata_reg, mdata_next;
    logic                    mlast_reg, mlast_next;

    logic [HALF_W-1:0]       h_eff;
    logic [CMP_W-1:0]        h_c;
    logic [CMP_W-1:0]        hp1;
    logic [CMP_W-1:0]        full_len;
    logic [PTR_W-1:0]        rcv_inc;
    logic                    emit_now;
    logic [PTR_W-1:0]        pend_dec;
    logic                    out_free;
    logic [SAMPLE_WIDTH-1:0] x;
    logic                    ram_we;
    logic [PTR_W-1:0]        ram_raddr;
    logic [SAMPLE_WIDTH-1:0] ram_rdata;
    logic                    div_start;
    div_stat_t               div_stat;
    logic [SAMPLE_WIDTH-1:0] div_mean;

    assign h_eff    = (half_reg > HALF_W'(H_LIM)) ? HALF_W'(H_LIM) : half_reg;
    assign h_c      = CMP_W'(h_eff);
    assign hp1      = h_c + CMP_W'(1);
    assign full_len = (h_c << 1) + CMP_W'(1);
    assign rcv_inc  = (CMP_W'(rcv_reg) < hp1) ? (rcv_reg + PTR_W'(1)) : rcv_reg;
    assign emit_now = CMP_W'(rcv_inc) == hp1;
    assign pend_dec = pend_reg - PTR_W'(1);
    assign out_free = !mvalid_reg || m_tready;
    assign x        = s_tdata[SAMPLE_WIDTH-1:0];
    assign ram_raddr = wptr_reg - cov_reg;

    always_comb begin
        state_next  = state_reg;
        half_next   = half_reg;
        sum_next    = sum_reg;
        wptr_next   = wptr_reg;
        rcv_next    = rcv_reg;
        cov_next    = cov_reg;
        pend_next   = pend_reg;
        main_next   = main_reg;
        fin_next    = fin_reg;
        olast_next  = olast_reg;
        drop_next   = drop_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;
        ram_we      = 1'b0;
        div_start   = 1'b0;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ram_we     = 1'b1;
                    sum_next   = sum_reg + {{PTR_W{x[SAMPLE_WIDTH-1]}}, x};
                    wptr_next  = wptr_reg + PTR_W'(1);
                    cov_next   = cov_reg + PTR_W'(1);
                    rcv_next   = rcv_inc;
                    main_next  = emit_now;
                    pend_next  = emit_now ? PTR_W'(h_eff) : rcv_inc;
                    fin_next   = s_tlast;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (main_reg) begin
                    div_start  = 1'b1;
                    olast_next = fin_reg && (h_eff == '0);
                    drop_next  = CMP_W'(cov_reg) >= full_len;
                    main_next  = 1'b0;
                    state_next = S_DIV;
                end else if (fin_reg && (pend_reg != '0)) begin
                    div_start  = 1'b1;
                    olast_next = pend_dec == '0;
                    drop_next  = CMP_W'(cov_reg) > (CMP_W'(pend_dec) + h_c);
                    pend_next  = pend_dec;
                    state_next = S_DIV;
                end else begin
                    // end of trace: start the next one from scratch
                    if (fin_reg) begin
                        sum_next  = '0;
                        wptr_next = '0;
                        rcv_next  = '0;
                        cov_next  = '0;
                        fin_next  = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    mdata_next  = div_mean;
                    mlast_next  = olast_reg;
                    state_next  = drop_reg ? S_DRD : S_CHECK;
                end
            end
            S_DRD: begin
                // oldest sample is read here, data lands next cycle
                state_next = S_DWT;
            end
            S_DWT: begin
                sum_next   = sum_reg - {{PTR_W{ram_rdata[SAMPLE_WIDTH-1]}}, ram_rdata};
                cov_next   = cov_reg - PTR_W'(1);
                state_next = S_CHECK;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wen) begin
            half_next = cfg_wdata;
            sum_next  = '0;
            wptr_next = '0;
            rcv_next  = '0;
            cov_next  = '0;
            fin_next  = 1'b0;
            main_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            half_reg   <= '0;
            sum_reg    <= '0;
            wptr_reg   <= '0;
            rcv_reg    <= '0;
            cov_reg    <= '0;
            pend_reg   <= '0;
            main_reg   <= 1'b0;
            fin_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            half_reg   <= half_next;
            sum_reg    <= sum_next;
            wptr_reg   <= wptr_next;
            rcv_reg    <= rcv_next;
            cov_reg    <= cov_next;
            pend_reg   <= pend_next;
            main_reg   <= main_next;
            fin_reg    <= fin_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        olast_reg <= olast_next;
        drop_reg  <= drop_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
    end

    cma_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (x),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cma_div #(
        .SUM_W (SUM_W),
        .CNT_W (PTR_W),
        .OUT_W (SAMPLE_WIDTH)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sum     (sum_reg),
        .count   (cov_reg),
        .stat    (div_stat),
        .mean    (div_mean)
    );

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = TDATA_W'(mdata_reg);
    assign m_tlast  = mlast_reg;

    `CMA_ASSERT_IMP(a_cov_bound, state_reg == S_IDLE, CMP_W'(cov_reg) <= (h_c << 1))
    `CMA_ASSERT_IMP(a_rcv_sat, 1'b1, CMP_W'(rcv_reg) <= hp1)
    `CMA_ASSERT_IMP(a_div_done, div_stat.done, state_reg == S_DIV)
    `CMA_ASSERT_IMP(a_div_busy, div_stat.busy, state_reg == S_DIV)
    `CMA_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule

`default_nettype wire
